>>> hdl/hhs_pkg.sv
// shared types and constants for the hillshade opacity filter
package hhs_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 12;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	// configuration register indexes
	localparam logic [3:0] CFG_FRAME_WIDTH  = 4'd0;
	localparam logic [3:0] CFG_FRAME_HEIGHT = 4'd1;
	localparam logic [3:0] CFG_BORDER       = 4'd2;
	localparam logic [3:0] CFG_RELIEF_SCALE = 4'd3;
	localparam logic [3:0] CFG_MAX_OPACITY  = 4'd4;
	localparam logic [3:0] CFG_SUN_HEIGHT   = 4'd5;
	localparam logic [3:0] CFG_SUN_EAST     = 4'd6;
	localparam logic [3:0] CFG_SUN_NORTH    = 4'd7;

	typedef struct packed {
		logic [11:0]        frame_width;
		logic [12:0]        frame_height;
		logic [6:0]         border;
		logic [15:0]        relief_scale;
		logic [7:0]         max_opacity;
		logic signed [15:0] sun_height_weight;
		logic signed [15:0] sun_east_weight;
		logic signed [15:0] sun_north_weight;
	} cfg_t;

	// one interior pixel handed from the front to the back
	typedef struct packed {
		logic signed [18:0] sx;
		logic signed [18:0] sy;
		logic               void_nb;
		logic               row_last;
		logic               frame_last;
	} job_t;

endpackage

>>> hdl/horn_hillshade_alpha.sv
// top level: hillshade opacity filter with configuration registers
// operation: a sample is taken and its window built in the front, then an interior pixel
//   goes through the back end (two 32-step roots, 32-step divide); a void one skips it
// the front takes one sample at a time (line store read then write-back), stalling on an
//   interior pixel while the job queue is full; the back shades one pixel at a time
// reset: line stores swept to zero over all 2048 columns with full high; config taken at all times
module horn_hillshade_alpha import hhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// sample requests
	input  logic        push,
	output logic        full,
	input  logic [15:0] height_sample,
	input  logic        sample_void,
	// result requests
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  shade_opacity,
	output logic        row_last,
	output logic        frame_last,
	// configuration requests
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	job_t front_job, back_job;
	logic job_push, job_full, job_pop, job_empty;

	// register writes never stall
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width       <= 12'd256;
			cfg_q.frame_height      <= 13'd256;
			cfg_q.border            <= 7'd1;
			cfg_q.relief_scale      <= 16'd256;
			cfg_q.max_opacity       <= 8'd255;
			cfg_q.sun_height_weight <= 16'sd11585;
			cfg_q.sun_east_weight   <= 16'sd0;
			cfg_q.sun_north_weight  <= 16'sd11585;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  cfg_q.frame_width       <= cfg_data[11:0];
				CFG_FRAME_HEIGHT: cfg_q.frame_height      <= cfg_data[12:0];
				CFG_BORDER:       cfg_q.border            <= cfg_data[6:0];
				CFG_RELIEF_SCALE: cfg_q.relief_scale      <= cfg_data;
				CFG_MAX_OPACITY:  cfg_q.max_opacity       <= cfg_data[7:0];
				CFG_SUN_HEIGHT:   cfg_q.sun_height_weight <= cfg_data;
				CFG_SUN_EAST:     cfg_q.sun_east_weight   <= cfg_data;
				CFG_SUN_NORTH:    cfg_q.sun_north_weight  <= cfg_data;
				// indexes past the list are ignored
				default: ;
			endcase
		end
	end

	// front: line stores, window, border test and horn sums
	hhs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.push          (push),
		.full          (full),
		.height_sample (height_sample),
		.sample_void   (sample_void),
		.job           (front_job),
		.job_push      (job_push),
		.job_full      (job_full)
	);

	// decoupling queue so each side stalls on its own
	hhs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (front_job),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (back_job),
		.empty  (job_empty)
	);

	// back: shading arithmetic and result register
	hhs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.job           (back_job),
		.job_empty     (job_empty),
		.job_pop       (job_pop),
		.shade_opacity (shade_opacity),
		.row_last      (row_last),
		.frame_last    (frame_last),
		.empty         (empty),
		.pop           (pop)
	);

endmodule

>>> hdl/hhs_front.sv
// front end: line stores, 3x3 window, interior test and horn sums
module hhs_front import hhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        push,
	output logic        full,
	input  logic [15:0] height_sample,
	input  logic        sample_void,
	output job_t        job,
	output logic        job_push,
	input  logic        job_full
);

	typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_RD} fstate_t;

	fstate_t           state_q;
	logic [COL_W-1:0]  clr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [16:0]       smp_q;
	logic [16:0]       win_q [0:5];
	logic [16:0]       upper_mem [0:MAX_WIDTH-1];
	logic [16:0]       middle_mem [0:MAX_WIDTH-1];
	logic [16:0]       up_rd_q;
	logic [16:0]       mid_rd_q;

	logic [COL_W:0]    w_eff;
	logic [12:0]       h_eff;
	logic [6:0]        bd_eff;
	logic [13:0]       cx, cy, bd14, w14, h14;
	logic              interior;
	logic              any_void;
	logic              advance;
	logic              col_wrap;
	logic              row_wrap;

	function automatic logic signed [18:0] hext(input logic [16:0] v);
		hext = {{3{v[15]}}, v[15:0]};
	endfunction

	always_comb begin
		if (cfg.frame_width < 12'd3) begin
			w_eff = (COL_W+1)'(3);
		end else if ({{(COL_W+1){1'b0}}, cfg.frame_width} > 24'(MAX_WIDTH)) begin
			w_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			w_eff = (COL_W+1)'(cfg.frame_width);
		end
		if (cfg.frame_height < 13'd3) begin
			h_eff = 13'd3;
		end else if (cfg.frame_height > 13'(MAX_HEIGHT)) begin
			h_eff = 13'(MAX_HEIGHT);
		end else begin
			h_eff = cfg.frame_height;
		end
		bd_eff = (cfg.border == 7'd0) ? 7'd1 : cfg.border;
	end

	assign cx   = 14'(col_q) - 14'd1;
	assign cy   = 14'(row_q) - 14'd1;
	assign bd14 = 14'(bd_eff);
	assign w14  = 14'(w_eff);
	assign h14  = 14'(h_eff);

	assign interior = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2)) &&
		(cy >= bd14) && (cy + 14'd1 + bd14 <= h14) &&
		(cx >= bd14) && (cx + 14'd1 + bd14 <= w14);

	// eight neighbours only, the centre is not examined
	assign any_void = win_q[0][16] | win_q[3][16] | up_rd_q[16] | win_q[1][16] |
		mid_rd_q[16] | win_q[2][16] | win_q[5][16] | smp_q[16];

	always_comb begin
		job.sx = hext(up_rd_q) + (hext(mid_rd_q) <<< 1) + hext(smp_q)
			- hext(win_q[0]) - (hext(win_q[1]) <<< 1) - hext(win_q[2]);
		job.sy = hext(win_q[0]) + (hext(win_q[3]) <<< 1) + hext(up_rd_q)
			- hext(win_q[2]) - (hext(win_q[5]) <<< 1) - hext(smp_q);
		job.void_nb    = any_void;
		job.row_last   = (cx + 14'd1 + bd14 == w14);
		job.frame_last = (cx + 14'd1 + bd14 == w14) && (cy + 14'd1 + bd14 == h14);
	end

	assign full     = (state_q != F_IDLE);
	assign job_push = (state_q == F_RD) && interior && !job_full;
	assign advance  = (state_q == F_RD) && (!interior || !job_full);
	assign col_wrap = ((COL_W+1)'(col_q) + (COL_W+1)'(1)) >= w_eff;
	assign row_wrap = (13'(row_q) + 13'd1) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLEAR;
			clr_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			smp_q   <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				F_CLEAR: begin
					clr_q <= clr_q + COL_W'(1);
					if (clr_q == COL_W'(MAX_WIDTH - 1)) begin
						state_q <= F_IDLE;
					end
				end
				F_IDLE: begin
					if (push) begin
						smp_q   <= {sample_void, height_sample};
						state_q <= F_RD;
					end
				end
				F_RD: begin
					if (advance) begin
						win_q[0] <= win_q[3];
						win_q[1] <= win_q[4];
						win_q[2] <= win_q[5];
						win_q[3] <= up_rd_q;
						win_q[4] <= mid_rd_q;
						win_q[5] <= smp_q;
						if (col_wrap) begin
							col_q <= '0;
							row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
						end else begin
							col_q <= col_q + COL_W'(1);
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_CLEAR) begin
			upper_mem[clr_q]  <= '0;
			middle_mem[clr_q] <= '0;
		end else if (advance) begin
			upper_mem[col_q]  <= mid_rd_q;
			middle_mem[col_q] <= smp_q;
		end
		up_rd_q  <= upper_mem[col_q];
		mid_rd_q <= middle_mem[col_q];
	end

endmodule

>>> hdl/hhs_queue.sv
// short job queue between front and back
module hhs_queue import hhs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output job_t dout,
	output logic empty
);

	job_t              mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop && !empty) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if ((push && !full) && !(pop && !empty)) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (!(push && !full) && (pop && !empty)) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

>>> hdl/hhs_isqrt.sv
// iterative integer square root, two radicand bits a cycle
module hhs_isqrt import hhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q, res_q, bit_q;
	logic        busy_q, done_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign busy  = busy_q;
	assign done  = done_q;
	assign root  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			v_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				v_q    <= radicand;
				res_q  <= '0;
				bit_q  <= 64'd1 << 62;
			end else if (busy_q) begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q == 64'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hdl/hhs_back.sv
// back end: slope scaling, lambert shade, divide, roots and opacity
module hhs_back import hhs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  job_t       job,
	input  logic       job_empty,
	output logic       job_pop,
	output logic [7:0] shade_opacity,
	output logic       row_last,
	output logic       frame_last,
	output logic       empty,
	input  logic       pop
);

	typedef enum logic [4:0] {
		B_IDLE, B_MULX, B_MULY, B_NORM, B_SQ0, B_SQ1, B_SQ2, B_N0, B_N1, B_N2,
		B_ROOT, B_RWAIT, B_AB, B_DIV, B_SHADE, B_SWAIT, B_OUT
	} bstate_t;

	bstate_t            st_q;
	job_t               job_q;
	logic signed [34:0] px_q, py_q;
	logic signed [30:0] gx_q, gy_q;
	logic [11:0]        g0_q;
	logic [63:0]        sum_q;
	logic signed [48:0] n_q;
	logic [30:0]        d_q;
	logic [48:0]        b_q;
	logic [48:0]        rem_q;
	logic [31:0]        quo_q;
	logic [4:0]         cnt_q;
	logic [16:0]        shade_q;
	logic               out_valid_q;
	logic [7:0]         op_q;
	logic               rl_q, fl_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic [34:0]        ax, ay, m, gxm, gym;
	logic [2:0]         k;
	logic signed [50:0] a_v;
	logic [48:0]        b_v;
	logic [49:0]        r2;
	logic [24:0]        sprod;
	logic [7:0]         op_v;
	logic               sq_start, sq_busy, sq_done;
	logic [63:0]        sq_in;
	logic [31:0]        sq_root;
	logic               out_load;

	hhs_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.busy     (sq_busy),
		.done     (sq_done),
		.root     (sq_root)
	);

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			B_MULX: begin
				mul_a = 32'(cfg.relief_scale);
				mul_b = 32'(job_q.sx);
			end
			B_MULY: begin
				mul_a = 32'(cfg.relief_scale);
				mul_b = 32'(job_q.sy);
			end
			B_SQ0: begin
				mul_a = 32'(g0_q);
				mul_b = 32'(g0_q);
			end
			B_SQ1: begin
				mul_a = 32'(gx_q);
				mul_b = 32'(gx_q);
			end
			B_SQ2: begin
				mul_a = 32'(gy_q);
				mul_b = 32'(gy_q);
			end
			B_N0: begin
				mul_a = 32'(cfg.sun_height_weight);
				mul_b = 32'(g0_q);
			end
			B_N1: begin
				mul_a = 32'(cfg.sun_east_weight);
				mul_b = 32'(gx_q);
			end
			B_N2: begin
				mul_a = 32'(cfg.sun_north_weight);
				mul_b = 32'(gy_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// range reduction so the scaled gradient stays below 2^30
	always_comb begin
		ax = px_q[34] ? 35'(-px_q) : 35'(px_q);
		ay = py_q[34] ? 35'(-py_q) : 35'(py_q);
		m  = 35'd2048;
		if (ax > m) begin
			m = ax;
		end
		if (ay > m) begin
			m = ay;
		end
		if (m[34]) begin
			k = 3'd5;
		end else if (m[33]) begin
			k = 3'd4;
		end else if (m[32]) begin
			k = 3'd3;
		end else if (m[31]) begin
			k = 3'd2;
		end else if (m[30]) begin
			k = 3'd1;
		end else begin
			k = 3'd0;
		end
		gxm = ax >> k;
		gym = ay >> k;
	end

	assign a_v = $signed({n_q, 2'b00}) + $signed({6'b0, d_q, 14'b0});
	assign b_v = 49'({d_q, 16'b0}) + 49'({d_q, 14'b0});
	assign r2  = {rem_q, 1'b0};

	assign sprod = 25'(shade_q) * 25'(cfg.max_opacity);
	assign op_v  = job_q.void_nb ? 8'd0 : cfg.max_opacity - sprod[23:16];

	assign sq_start = (st_q == B_ROOT) || (st_q == B_SHADE);
	assign sq_in    = (st_q == B_ROOT) ? sum_q : {32'b0, quo_q};
	assign job_pop  = (st_q == B_IDLE) && !job_empty;
	assign out_load = (st_q == B_OUT) && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			job_q   <= '0;
			px_q    <= '0;
			py_q    <= '0;
			gx_q    <= '0;
			gy_q    <= '0;
			g0_q    <= '0;
			sum_q   <= '0;
			n_q     <= '0;
			d_q     <= '0;
			b_q     <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			shade_q <= '0;
		end else begin
			unique case (st_q)
				B_IDLE: begin
					if (!job_empty) begin
						job_q <= job;
						st_q  <= job.void_nb ? B_OUT : B_MULX;
					end
				end
				B_MULX: begin
					px_q <= prod[34:0];
					st_q <= B_MULY;
				end
				B_MULY: begin
					py_q <= prod[34:0];
					st_q <= B_NORM;
				end
				B_NORM: begin
					gx_q <= px_q[34] ? -$signed({1'b0, gxm[29:0]}) : $signed({1'b0, gxm[29:0]});
					gy_q <= py_q[34] ? -$signed({1'b0, gym[29:0]}) : $signed({1'b0, gym[29:0]});
					g0_q <= 12'd2048 >> k;
					st_q <= B_SQ0;
				end
				B_SQ0: begin
					sum_q <= $unsigned(prod);
					st_q  <= B_SQ1;
				end
				B_SQ1: begin
					sum_q <= sum_q + $unsigned(prod);
					st_q  <= B_SQ2;
				end
				B_SQ2: begin
					sum_q <= sum_q + $unsigned(prod);
					st_q  <= B_N0;
				end
				B_N0: begin
					n_q  <= $signed(prod[48:0]);
					st_q <= B_N1;
				end
				B_N1: begin
					n_q  <= n_q - $signed(prod[48:0]);
					st_q <= B_N2;
				end
				B_N2: begin
					n_q  <= n_q - $signed(prod[48:0]);
					st_q <= B_ROOT;
				end
				B_ROOT: begin
					st_q <= B_RWAIT;
				end
				B_RWAIT: begin
					if (sq_done) begin
						d_q  <= sq_root[30:0];
						st_q <= B_AB;
					end
				end
				B_AB: begin
					if (a_v <= 51'sd0 || b_v == 49'd0) begin
						shade_q <= 17'd0;
						st_q    <= B_OUT;
					end else if ($unsigned(a_v) >= {2'b00, b_v}) begin
						shade_q <= 17'd65536;
						st_q    <= B_OUT;
					end else begin
						rem_q <= a_v[48:0];
						b_q   <= b_v;
						quo_q <= '0;
						cnt_q <= '0;
						st_q  <= B_DIV;
					end
				end
				B_DIV: begin
					if (r2 >= {1'b0, b_q}) begin
						rem_q <= 49'(r2 - {1'b0, b_q});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= r2[48:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						st_q <= B_SHADE;
					end
				end
				B_SHADE: begin
					st_q <= B_SWAIT;
				end
				B_SWAIT: begin
					if (sq_done) begin
						shade_q <= {1'b0, sq_root[15:0]};
						st_q    <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_load) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			op_q        <= '0;
			rl_q        <= 1'b0;
			fl_q        <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				op_q        <= op_v;
				rl_q        <= job_q.row_last;
				fl_q        <= job_q.frame_last;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty         = !out_valid_q;
	assign shade_opacity = op_q;
	assign row_last      = rl_q;
	assign frame_last    = fl_q;

	a_root_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_busy)
		else $error("root unit started while busy");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_DIV) |-> (b_q != 49'd0))
		else $error("divide by zero divisor");

	a_root_to_ab: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_RWAIT && sq_done) |=> (st_q == B_AB))
		else $error("norm root not followed by argument stage");

	a_shade_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_OUT && !job_q.void_nb) |-> (shade_q <= 17'd65536))
		else $error("shade above one");

endmodule
